// File: rtl/bect_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bect_pkg
// Shared constants and helpers for the cubic Bezier easing curve table.
// ----------------------------------------------------------------------------
package bect_pkg;

    localparam int DEF_TABLE_DIVISIONS  = 16;
    localparam int DEF_MAX_SOLVE_PASSES = 32;

    localparam int CTRL_W = 7;
    localparam int POS_W  = 17;
    localparam int IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_X1 = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_X2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_Y2 = 2'd3;

    localparam logic [CTRL_W-1:0] RST_X1 = 7'd20;
    localparam logic [CTRL_W-1:0] RST_Y1 = 7'd20;
    localparam logic [CTRL_W-1:0] RST_X2 = 7'd107;
    localparam logic [CTRL_W-1:0] RST_Y2 = 7'd107;

    localparam logic [POS_W-1:0] Q_ONE = 17'd65536;

    // Solver value widths
    localparam int ACC_W = 26;
    localparam int T_W   = 19;
    localparam int MUL_W = 24;
    localparam int PRD_W = 2 * MUL_W;

    localparam logic signed [ACC_W-1:0] SOLVE_TOL = 26'sd7;
    localparam logic signed [T_W-1:0]   T_MIN     = -19'sd65536;
    localparam logic signed [T_W-1:0]   T_MAX     = 19'sd131072;

    // Bernstein weight 3*c/127 in Q16, rounded to nearest.
    // 196608 = 127*1548 + 12, so the weight is 1548*c plus (12*c + 63)/127,
    // and that small quotient comes from a multiply by 2065 and a shift by 18.
    function automatic logic [17:0] weight_of(input logic [CTRL_W-1:0] c);
        logic [10:0] part;
        logic [22:0] quo;
        part = 11'(c) * 11'd12 + 11'd63;
        quo  = 23'(part) * 23'd2065;
        return 18'(c) * 18'd1548 + 18'(quo[22:18]);
    endfunction

    // Q16 rounding of a signed product, halves away from zero
    function automatic logic signed [ACC_W-1:0] qround(input logic signed [PRD_W-1:0] p);
        logic [PRD_W-1:0] mag;
        logic [PRD_W-1:0] sh;
        mag = p[PRD_W-1] ? PRD_W'(-p) : PRD_W'(p);
        sh  = (mag + PRD_W'(32768)) >> 16;
        return p[PRD_W-1] ? -$signed(sh[ACC_W-1:0]) : $signed(sh[ACC_W-1:0]);
    endfunction

endpackage
`default_nettype wire

// File: rtl/bezier_easing_curve_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_easing_curve_table_top
// Cubic Bezier easing curve, Q1.16 position in, Q1.16 eased value out.
// ----------------------------------------------------------------------------
// A query on a straight curve (x1==y1, x2==y2) returns the position capped at one;
// a position at or above one reads only the last table entry; any other takes two
// table reads through the single memory read port and two products on the
// shared multiplier. After each configuration write that leaves the curve
// curved the block rebuilds its table and holds o_in_stall high meanwhile:
// first the end entries, then per inner sample up to MAX_SOLVE_PASSES+1
// curve evaluations of 8 multiply/round steps each.
// ----------------------------------------------------------------------------
module bezier_easing_curve_table_top #(
    parameter int TABLE_DIVISIONS  = bect_pkg::DEF_TABLE_DIVISIONS,
    parameter int MAX_SOLVE_PASSES = bect_pkg::DEF_MAX_SOLVE_PASSES
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bect_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire [bect_pkg::CTRL_W-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [bect_pkg::POS_W-1:0]    i_position,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [bect_pkg::POS_W-1:0]   o_eased_value
);

    localparam int AW     = $clog2(TABLE_DIVISIONS + 1);
    localparam int PW     = $clog2(MAX_SOLVE_PASSES + 1);
    localparam int RW     = $clog2(TABLE_DIVISIONS) + 1;
    localparam int DEPTH  = TABLE_DIVISIONS + 1;
    localparam int XSTEP_Q = 65536 / TABLE_DIVISIONS;
    localparam int XSTEP_R = 65536 % TABLE_DIVISIONS;
    localparam int SC_W   = 16 + AW;

    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DIVISIONS);
    localparam logic [AW-1:0] PRE_LAST = AW'(TABLE_DIVISIONS - 1);
    localparam logic [PW-1:0] PASS_END = PW'(MAX_SOLVE_PASSES - 1);
    localparam logic [RW-1:0] REM_STEP = RW'(XSTEP_R);
    localparam logic [RW-1:0] REM_DIV  = RW'(TABLE_DIVISIONS);
    localparam logic [16:0]   X_STEP   = 17'(XSTEP_Q);

    typedef enum logic [3:0] {
        S_IDLE, S_QRA, S_QRB, S_QM1, S_QM2, S_QM3, S_OUT,
        S_BINIT0, S_BINIT1, S_BMUL, S_BRND, S_BEVAL
    } t_state;

    t_state r_state;

    logic [bect_pkg::CTRL_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [bect_pkg::CTRL_W-1:0] n_x1, n_y1, n_x2, n_y2;
    logic                        cfg_hit;

    logic [bect_pkg::POS_W-1:0]  mem [DEPTH];
    logic [bect_pkg::POS_W-1:0]  r_rd;
    logic [AW-1:0]               rd_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [bect_pkg::POS_W-1:0]  mem_wd;

    // query registers
    logic [AW-1:0]               r_idx;
    logic [15:0]                 r_frac;
    logic                        r_last;
    logic [bect_pkg::POS_W-1:0]  r_a;
    logic [33:0]                 r_sum;
    logic [bect_pkg::POS_W-1:0]  r_res;

    // solver registers
    logic signed [bect_pkg::T_W-1:0]   r_t;
    logic signed [bect_pkg::ACC_W-1:0] r_q, r_acc;
    logic [2:0]                        r_step;
    logic [PW-1:0]                     r_pass;
    logic                              r_ymode;
    logic [AW-1:0]                     r_i;
    logic [16:0]                       r_x;
    logic [RW-1:0]                     r_rem;

    logic signed [bect_pkg::PRD_W-1:0] r_prod;
    logic signed [bect_pkg::MUL_W-1:0] m_a, m_b;

    logic                        straight;
    logic [bect_pkg::POS_W-1:0]  pos_sat;
    logic [SC_W-1:0]             scaled;
    logic signed [bect_pkg::T_W-1:0]   inv;
    logic signed [bect_pkg::MUL_W-1:0] w1, w2;
    logic signed [bect_pkg::ACC_W-1:0] rnd_v, err, half, y_v;
    logic signed [bect_pkg::ACC_W:0]   nt_w;
    logic signed [bect_pkg::T_W-1:0]   nt;
    logic [RW-1:0]                     rem_sum;
    logic [16:0]                       x_next;
    logic [RW-1:0]                     rem_next;

    // configuration next values
    always_comb begin
        n_x1 = r_x1;
        n_y1 = r_y1;
        n_x2 = r_x2;
        n_y2 = r_y2;
        cfg_hit = i_cfg_we;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bect_pkg::REG_X1: n_x1 = i_cfg_data;
                bect_pkg::REG_Y1: n_y1 = i_cfg_data;
                bect_pkg::REG_X2: n_x2 = i_cfg_data;
                bect_pkg::REG_Y2: n_y2 = i_cfg_data;
                default:          cfg_hit = 1'b0;
            endcase
        end
    end

    assign straight = (r_x1 == r_y1) && (r_x2 == r_y2);
    assign pos_sat  = (i_position > bect_pkg::Q_ONE) ? bect_pkg::Q_ONE : i_position;
    assign scaled   = SC_W'(pos_sat) * SC_W'(TABLE_DIVISIONS);

    assign inv = bect_pkg::T_W'(19'sd65536 - r_t);
    assign w1  = $signed(bect_pkg::MUL_W'(bect_pkg::weight_of(r_ymode ? r_y1 : r_x1)));
    assign w2  = $signed(bect_pkg::MUL_W'(bect_pkg::weight_of(r_ymode ? r_y2 : r_x2)));

    // shared multiplier operand select
    always_comb begin
        m_a = bect_pkg::MUL_W'(r_q);
        m_b = bect_pkg::MUL_W'(r_t);
        priority if (r_state == S_QM1) begin
            m_a = $signed(bect_pkg::MUL_W'(r_a));
            m_b = $signed(bect_pkg::MUL_W'(bect_pkg::Q_ONE - {1'b0, r_frac}));
        end else if (r_state == S_QM2) begin
            m_a = $signed(bect_pkg::MUL_W'(r_rd));
            m_b = $signed(bect_pkg::MUL_W'({1'b0, r_frac}));
        end else begin
            unique case (r_step)
                3'd0: begin m_a = bect_pkg::MUL_W'(inv); m_b = bect_pkg::MUL_W'(inv); end
                3'd1: begin m_a = bect_pkg::MUL_W'(r_q); m_b = bect_pkg::MUL_W'(r_t); end
                3'd2: begin m_a = bect_pkg::MUL_W'(r_q); m_b = w1;                    end
                3'd3: begin m_a = bect_pkg::MUL_W'(inv); m_b = bect_pkg::MUL_W'(r_t); end
                3'd4: begin m_a = bect_pkg::MUL_W'(r_q); m_b = bect_pkg::MUL_W'(r_t); end
                3'd5: begin m_a = bect_pkg::MUL_W'(r_q); m_b = w2;                    end
                3'd6: begin m_a = bect_pkg::MUL_W'(r_t); m_b = bect_pkg::MUL_W'(r_t); end
                default: begin m_a = bect_pkg::MUL_W'(r_q); m_b = bect_pkg::MUL_W'(r_t); end
            endcase
        end
    end

    assign rnd_v = bect_pkg::qround(r_prod);
    assign err   = r_acc - $signed({{(bect_pkg::ACC_W-17){1'b0}}, r_x});
    assign half  = (err + $signed(bect_pkg::ACC_W'(err[bect_pkg::ACC_W-1]))) >>> 1;
    assign nt_w  = (bect_pkg::ACC_W+1)'(r_t) - (bect_pkg::ACC_W+1)'(half);

    always_comb begin
        if (nt_w < (bect_pkg::ACC_W+1)'(bect_pkg::T_MIN)) begin
            nt = bect_pkg::T_MIN;
        end else if (nt_w > (bect_pkg::ACC_W+1)'(bect_pkg::T_MAX)) begin
            nt = bect_pkg::T_MAX;
        end else begin
            nt = bect_pkg::T_W'(nt_w);
        end
    end

    always_comb begin
        if (r_acc < 0) begin
            y_v = '0;
        end else if (r_acc > 26'sd65536) begin
            y_v = 26'sd65536;
        end else begin
            y_v = r_acc;
        end
    end

    // advance sample x by 65536/DIVISIONS, carrying the remainder
    assign rem_sum = r_rem + REM_STEP;
    always_comb begin
        if (rem_sum >= REM_DIV) begin
            x_next   = r_x + X_STEP + 17'd1;
            rem_next = rem_sum - REM_DIV;
        end else begin
            x_next   = r_x + X_STEP;
            rem_next = rem_sum;
        end
    end

    // memory port control
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_i;
        mem_wd  = bect_pkg::POS_W'(y_v);
        rd_addr = r_last ? LAST_IDX : r_idx;
        unique case (r_state)
            S_BINIT0: begin mem_we = 1'b1; mem_wa = '0;       mem_wd = '0;             end
            S_BINIT1: begin mem_we = 1'b1; mem_wa = LAST_IDX; mem_wd = bect_pkg::Q_ONE; end
            S_BEVAL:  mem_we = r_ymode;
            // hold the upper entry on the read port until the second product
            S_QRB, S_QM1: rd_addr = r_last ? LAST_IDX : r_idx + AW'(1);
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x1        <= bect_pkg::RST_X1;
            r_y1        <= bect_pkg::RST_Y1;
            r_x2        <= bect_pkg::RST_X2;
            r_y2        <= bect_pkg::RST_Y2;
            o_out_valid <= 1'b0;
            r_step      <= '0;
            r_pass      <= '0;
            r_ymode     <= 1'b0;
            r_i         <= '0;
        end else begin
            if (o_out_valid && !i_out_stall && (cfg_hit || r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end
            // a register write restarts the table build, or goes idle if the new curve is straight
            if (cfg_hit) begin
                r_x1 <= n_x1;
                r_y1 <= n_y1;
                r_x2 <= n_x2;
                r_y2 <= n_y2;
                r_state <= ((n_x1 == n_y1) && (n_x2 == n_y2)) ? S_IDLE : S_BINIT0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_idx  <= scaled[SC_W-1:16];
                            r_frac <= scaled[15:0];
                            r_last <= (scaled[SC_W-1:16] >= LAST_IDX);
                            r_res  <= pos_sat;
                            r_state <= straight ? S_OUT : S_QRA;
                        end
                    end
                    S_QRA: r_state <= S_QRB;
                    S_QRB: begin
                        r_a <= r_rd;
                        if (r_last) begin
                            r_res   <= r_rd;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_QM1;
                        end
                    end
                    S_QM1: r_state <= S_QM2;
                    S_QM2: begin
                        r_sum   <= 34'(r_prod);
                        r_state <= S_QM3;
                    end
                    S_QM3: begin
                        r_res   <= bect_pkg::POS_W'((r_sum + 34'(r_prod) + 34'd32768) >> 16);
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        // hold until the output register frees up
                        if (!o_out_valid || !i_out_stall) begin
                            o_eased_value <= r_res;
                            o_out_valid   <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    end
                    S_BINIT0: r_state <= S_BINIT1;
                    S_BINIT1: begin
                        r_i     <= AW'(1);
                        r_x     <= X_STEP;
                        r_rem   <= REM_STEP;
                        r_t     <= bect_pkg::T_W'(X_STEP);
                        r_pass  <= '0;
                        r_ymode <= 1'b0;
                        r_step  <= '0;
                        r_state <= S_BMUL;
                    end
                    S_BMUL: r_state <= S_BRND;
                    S_BRND: begin
                        unique case (r_step)
                            3'd2:       r_acc <= rnd_v;
                            3'd5, 3'd7: r_acc <= r_acc + rnd_v;
                            default:    r_q   <= rnd_v;
                        endcase
                        r_step  <= r_step + 3'd1;
                        r_state <= (r_step == 3'd7) ? S_BEVAL : S_BMUL;
                    end
                    S_BEVAL: begin
                        if (!r_ymode) begin
                            r_state <= S_BMUL;
                            if (err > -bect_pkg::SOLVE_TOL && err < bect_pkg::SOLVE_TOL) begin
                                r_ymode <= 1'b1;
                            end else begin
                                r_t    <= nt;
                                r_pass <= r_pass + PW'(1);
                                if (r_pass == PASS_END) begin
                                    r_ymode <= 1'b1;
                                end
                            end
                        end else if (r_i == PRE_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_BMUL;
                            r_i     <= r_i + AW'(1);
                            r_x     <= x_next;
                            r_rem   <= rem_next;
                            r_t     <= bect_pkg::T_W'(x_next);
                            r_pass  <= '0;
                            r_ymode <= 1'b0;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: tb/bect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bect_checker
// Watches the configuration port and both word channels of the easing curve
// block, keeps its own copy of the control points and sample table, predicts
// each eased value and compares it with what the block returns.
// ----------------------------------------------------------------------------
module bect_checker #(
    parameter int DIVS   = bect_pkg::DEF_TABLE_DIVISIONS,
    parameter int PASSES = bect_pkg::DEF_MAX_SOLVE_PASSES
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bect_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire [bect_pkg::CTRL_W-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_stall,
    input  wire [bect_pkg::POS_W-1:0]    i_position,
    input  wire                          i_out_valid,
    input  wire                          i_out_stall,
    input  wire [bect_pkg::POS_W-1:0]    i_eased_value,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_words_checked
);

    logic [bect_pkg::CTRL_W-1:0] cx1, cy1, cx2, cy2;
    logic [bect_pkg::POS_W-1:0]  samples [DIVS+1];
    logic                        straight;
    logic [bect_pkg::POS_W-1:0]  eased_due [$];

    function automatic longint q16_mul(longint a, longint b);
        longint p;
        p = a * b;
        return (p >= 0) ? (p + 32768) / 65536 : -((-p + 32768) / 65536);
    endfunction

    function automatic longint bern_weight(logic [bect_pkg::CTRL_W-1:0] c);
        return (longint'(c) * 3 * 65536 + 63) / 127;
    endfunction

    function automatic longint bezier_at(longint t, longint w1, longint w2);
        longint inv;
        inv = 65536 - t;
        return q16_mul(q16_mul(q16_mul(inv, inv), t), w1)
             + q16_mul(q16_mul(q16_mul(inv, t), t), w2)
             + q16_mul(q16_mul(t, t), t);
    endfunction

    // Damped solve of x(t) = x, then y at the final t, clamped to [0, one]
    function automatic logic [bect_pkg::POS_W-1:0] solve_y(longint x, longint wx1,
                                                           longint wy1, longint wx2,
                                                           longint wy2);
        longint t, err, y;
        t = x;
        for (int n = 0; n < PASSES; n++) begin
            err = bezier_at(t, wx1, wx2) - x;
            if (err > -7 && err < 7) break;
            t = t - err / 2;
            if (t < -65536) t = -65536;
            if (t > 131072) t = 131072;
        end
        y = bezier_at(t, wy1, wy2);
        if (y < 0) y = 0;
        if (y > 65536) y = 65536;
        return bect_pkg::POS_W'(y);
    endfunction

    task automatic rebuild_samples();
        longint wx1, wy1, wx2, wy2;
        if (cx1 == cy1 && cx2 == cy2) begin
            straight = 1'b1;
            return;
        end
        wx1 = bern_weight(cx1);
        wy1 = bern_weight(cy1);
        wx2 = bern_weight(cx2);
        wy2 = bern_weight(cy2);
        samples[0]    = '0;
        samples[DIVS] = bect_pkg::Q_ONE;
        for (int i = 1; i < DIVS; i++)
            samples[i] = solve_y((longint'(i) * 65536) / DIVS, wx1, wy1, wx2, wy2);
        straight = 1'b0;
    endtask

    function automatic logic [bect_pkg::POS_W-1:0] ease(logic [bect_pkg::POS_W-1:0] pos_in);
        longint pos, scaled, idx, frac;
        pos = (pos_in > bect_pkg::Q_ONE) ? 65536 : longint'(pos_in);
        if (straight) return bect_pkg::POS_W'(pos);
        scaled = pos * DIVS;
        idx    = scaled >> 16;
        frac   = scaled & 16'hFFFF;
        if (idx >= DIVS) return samples[DIVS];
        return bect_pkg::POS_W'((longint'(samples[idx]) * (65536 - frac)
                                + longint'(samples[idx + 1]) * frac + 32768) >> 16);
    endfunction

    assign o_pending = eased_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cx1 = bect_pkg::RST_X1;
            cy1 = bect_pkg::RST_Y1;
            cx2 = bect_pkg::RST_X2;
            cy2 = bect_pkg::RST_Y2;
            straight = 1'b1;
            eased_due.delete();
            o_fail_count    <= 0;
            o_words_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bect_pkg::REG_X1: cx1 = i_cfg_data;
                    bect_pkg::REG_Y1: cy1 = i_cfg_data;
                    bect_pkg::REG_X2: cx2 = i_cfg_data;
                    bect_pkg::REG_Y2: cy2 = i_cfg_data;
                    default: ;
                endcase
                rebuild_samples();
            end
            if (i_in_valid && !i_in_stall)
                eased_due.push_back(ease(i_position));
            if (i_out_valid && !i_out_stall) begin
                o_words_checked <= o_words_checked + 1;
                if (eased_due.size() == 0) begin
                    $error("unexpected word: eased_value %0d", i_eased_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (eased_due[0] !== i_eased_value) begin
                    $error("eased_value: expected %0d, actual %0d",
                           eased_due[0], i_eased_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(eased_due.pop_front());
                end else begin
                    void'(eased_due.pop_front());
                end
            end
        end
    end

endmodule

// File: tb/tb_bezier_easing_curve_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_easing_curve_table_top
// Drives control point settings and positions into the easing curve block
// under several idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bezier_easing_curve_table_top;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam int NUM_CFGS  = 9;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [bect_pkg::IDX_W-1:0]  i_cfg_index = bect_pkg::REG_X1;
    logic [bect_pkg::CTRL_W-1:0] i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic [bect_pkg::POS_W-1:0]  i_position = '0;
    logic                        i_out_stall = 1'b0;
    wire                         o_in_stall;
    wire                         o_out_valid;
    wire [bect_pkg::POS_W-1:0]   o_eased_value;
    int                          fail_count, pending, words_checked;
    int                          idle_mode = IDLE_NONE;
    int                          cfg_count = 0;

    logic [bect_pkg::CTRL_W-1:0] cfg_set [NUM_CFGS][4] = '{
        '{7'd0,   7'd127, 7'd127, 7'd0},
        '{7'd127, 7'd0,   7'd0,   7'd127},
        '{7'd0,   7'd0,   7'd0,   7'd0},
        '{7'd127, 7'd127, 7'd127, 7'd127},
        '{7'd0,   7'd0,   7'd127, 7'd127},
        '{7'd42,  7'd0,   7'd74,  7'd127},
        '{7'd127, 7'd127, 7'd0,   7'd0},
        '{7'd85,  7'd120, 7'd5,   7'd60},
        '{7'd20,  7'd20,  7'd107, 7'd107}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bezier_easing_curve_table_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_position(i_position),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_eased_value(o_eased_value)
    );

    bect_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_position(i_position),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_eased_value(o_eased_value),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_words_checked(words_checked)
    );

    // Receiver stall follows the current idle pattern
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECV)
            i_out_stall <= ($urandom_range(99) < 76);
        else if (idle_mode == IDLE_BOTH)
            i_out_stall <= ($urandom_range(99) < 25);
        else
            i_out_stall <= 1'b0;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    task automatic send_position(logic [bect_pkg::POS_W-1:0] pos);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 76 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_in_valid <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Write one control register, then hold until the table rebuild ends
    task automatic write_reg(logic [bect_pkg::IDX_W-1:0] idx,
                             logic [bect_pkg::CTRL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cfg_count++;
    endtask

    function automatic logic [bect_pkg::POS_W-1:0] rand_position();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return bect_pkg::POS_W'($urandom_range(131071, 65537));
        if (r < 14) return (r < 10) ? bect_pkg::Q_ONE
                                    : bect_pkg::POS_W'($urandom_range(65535, 65520));
        if (r < 20) return bect_pkg::POS_W'($urandom_range(15));
        if (r < 30) return bect_pkg::POS_W'($urandom_range(16) * 4096);
        return bect_pkg::POS_W'($urandom_range(65536));
    endfunction

    logic [bect_pkg::POS_W-1:0] directed [14] = '{
        17'd0, 17'd1, 17'd4095, 17'd4096, 17'd4097, 17'd32768, 17'd61440,
        17'd65535, 17'd65536, 17'd65537, 17'h1FFFF, 17'h10000, 17'h0FFFF, 17'h15555
    };

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset curve is a straight line
        foreach (directed[k]) send_position(directed[k]);
        drain();

        for (int c = 0; c < NUM_CFGS; c++) begin
            write_reg(bect_pkg::REG_X1, cfg_set[c][0]);
            write_reg(bect_pkg::REG_Y1, cfg_set[c][1]);
            write_reg(bect_pkg::REG_X2, cfg_set[c][2]);
            write_reg(bect_pkg::REG_Y2, cfg_set[c][3]);
            idle_mode = IDLE_NONE;
            foreach (directed[k]) send_position(directed[k]);
            for (int n = 0; n < 200; n++) begin
                idle_mode = (n / 50 + c) % 4;
                send_position(rand_position());
                // Hold off once until every result is back
                if (c == 3 && n == 100) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
            end
            idle_mode = IDLE_NONE;
            drain();
        end

        $display("covered %0d register writes over %0d curve settings, %0d words checked",
                 cfg_count, NUM_CFGS, words_checked);
        $display("under no idling, sender gaps, receiver stalls and both combined");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: bezier_easing_curve_table_top.f
rtl/bect_pkg.sv
rtl/bezier_easing_curve_table_top.sv
tb/bect_checker.sv
tb/tb_bezier_easing_curve_table_top.sv
